// ===== rtl/frta_pkg.sv =====
package frta_pkg;

   localparam int MAX_RANGES = 64;
   localparam int PAGE_BYTES = 4096;
   localparam int ADDR_W     = 64;
   localparam int CNT_W      = $clog2(MAX_RANGES + 1);

   localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE_BYTES - 1);
   localparam logic [ADDR_W-1:0] PAGE_LEN  = ADDR_W'(PAGE_BYTES);
   localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_RANGES);

   localparam logic [2:0] OP_CLEAR   = 3'd0;
   localparam logic [2:0] OP_ADD     = 3'd1;
   localparam logic [2:0] OP_RESERVE = 3'd2;
   localparam logic [2:0] OP_ALLOC   = 3'd3;
   localparam logic [2:0] OP_READY   = 3'd4;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_FAIL = 2'd1;
   localparam logic [1:0] ST_DROP = 2'd2;

   typedef struct packed {
      logic              scan_rst;
      logic              scan_adv;
      logic              cnt_clr;
      logic              cnt_inc;
      logic              cnt_dec;
      logic              cnt_full;
      logic              wr_scan_start;
      logic              wr_scan_end;
      logic              wr_app;
      logic [ADDR_W-1:0] scan_start_val;
      logic [ADDR_W-1:0] scan_end_val;
      logic [ADDR_W-1:0] app_start_val;
      logic [ADDR_W-1:0] app_end_val;
   } cmd_type;

endpackage

// ===== rtl/free_range_table_allocator.sv =====
// Free range table allocator: holds up to 64 page-aligned free ranges in a row of cells and
// serves clear, add, reserve, allocate (first fit) and mark-ready words, one result word per
// request word. Requests are taken one at a time. Clear, add, mark ready, unused codes, an
// empty reserve and an allocate that cannot start go from the decode state to the result.
// Reserve scans the ranges, split-off ranges included, and trims, splits or removes each
// one that it overlaps; allocate tries the ranges in order until one fits. A single head
// reads the cells through a token that moves down the row, and allocate reads each cell in
// states S_ALA and S_ALB for its two address adds. The next word can be accepted in the
// cycle after the result is loaded. A result waiting in the output register holds the next
// result back, not the next accept. csr writes are registered and should be made while no
// request is in flight.
module free_range_table_allocator import frta_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_operation,
   input  logic [ADDR_W-1:0] req_start_addr,
   input  logic [ADDR_W-1:0] req_end_addr,
   input  logic [ADDR_W-1:0] req_request_size,
   input  logic [ADDR_W-1:0] req_request_align,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [ADDR_W-1:0] rsp_mapped_address,
   output logic [ADDR_W-1:0] rsp_granted_phys,
   output logic [ADDR_W-1:0] rsp_granted_size,
   output logic [ADDR_W-1:0] rsp_free_bytes,
   output logic [6:0]        rsp_range_count,
   output logic [ADDR_W-1:0] rsp_highest_address,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [ADDR_W-1:0] csr_map_offset
);

   cmd_type           cmd;
   logic              scan_tok [MAX_RANGES];
   logic              cnt_tok  [MAX_RANGES];
   logic [ADDR_W-1:0] c_scan_start [MAX_RANGES];
   logic [ADDR_W-1:0] c_scan_end   [MAX_RANGES];
   logic [ADDR_W-1:0] c_tail_start [MAX_RANGES];
   logic [ADDR_W-1:0] c_tail_end   [MAX_RANGES];
   logic [ADDR_W-1:0] scan_start_bus, scan_end_bus, tail_start_bus, tail_end_bus;

   for (genvar k = 0; k < MAX_RANGES; k++) begin : g_cell
      frta_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .is_first   ((k == 0) ? 1'b1 : 1'b0),
         .cmd        (cmd),
         .scan_left  ((k == 0) ? 1'b0 : scan_tok[(k == 0) ? 0 : k - 1]),
         .cnt_left   ((k == 0) ? 1'b0 : cnt_tok[(k == 0) ? 0 : k - 1]),
         .cnt_right  ((k == MAX_RANGES - 1) ? cmd.cnt_full
                                            : cnt_tok[(k == MAX_RANGES - 1) ? k : k + 1]),
         .scan_tok   (scan_tok[k]),
         .cnt_tok    (cnt_tok[k]),
         .scan_start (c_scan_start[k]),
         .scan_end   (c_scan_end[k]),
         .tail_start (c_tail_start[k]),
         .tail_end   (c_tail_end[k])
      );
   end

   // one-hot token selects, so an or over the row picks the cell
   always_comb begin
      scan_start_bus = '0;
      scan_end_bus   = '0;
      tail_start_bus = '0;
      tail_end_bus   = '0;
      for (int k = 0; k < MAX_RANGES; k++) begin
         scan_start_bus = scan_start_bus | c_scan_start[k];
         scan_end_bus   = scan_end_bus | c_scan_end[k];
         tail_start_bus = tail_start_bus | c_tail_start[k];
         tail_end_bus   = tail_end_bus | c_tail_end[k];
      end
   end

   frta_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_start_addr      (req_start_addr),
      .req_end_addr        (req_end_addr),
      .req_request_size    (req_request_size),
      .req_request_align   (req_request_align),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_mapped_address  (rsp_mapped_address),
      .rsp_granted_phys    (rsp_granted_phys),
      .rsp_granted_size    (rsp_granted_size),
      .rsp_free_bytes      (rsp_free_bytes),
      .rsp_range_count     (rsp_range_count),
      .rsp_highest_address (rsp_highest_address),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_map_offset      (csr_map_offset),
      .scan_start_bus      (scan_start_bus),
      .scan_end_bus        (scan_end_bus),
      .tail_start_bus      (tail_start_bus),
      .tail_end_bus        (tail_end_bus),
      .cmd                 (cmd)
   );

endmodule

// ===== rtl/frta_cell.sv =====
module frta_cell import frta_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              is_first,
   input  cmd_type           cmd,
   input  logic              scan_left,
   input  logic              cnt_left,
   input  logic              cnt_right,
   output logic              scan_tok,
   output logic              cnt_tok,
   output logic [ADDR_W-1:0] scan_start,
   output logic [ADDR_W-1:0] scan_end,
   output logic [ADDR_W-1:0] tail_start,
   output logic [ADDR_W-1:0] tail_end
);

   logic              scan_ff, scan_in;
   logic              cnt_ff, cnt_in;
   logic [ADDR_W-1:0] start_ff, start_in;
   logic [ADDR_W-1:0] end_ff, end_in;

   always_comb begin
      scan_in = scan_ff;
      if (cmd.scan_rst) begin
         scan_in = is_first;
      end else if (cmd.scan_adv) begin
         scan_in = scan_left;
      end
      cnt_in = cnt_ff;
      if (cmd.cnt_clr) begin
         cnt_in = is_first;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_left;
      end else if (cmd.cnt_dec) begin
         cnt_in = cnt_right;
      end
      start_in = start_ff;
      end_in   = end_ff;
      if (scan_ff && cmd.wr_scan_start) begin
         start_in = cmd.scan_start_val;
      end
      if (scan_ff && cmd.wr_scan_end) begin
         end_in = cmd.scan_end_val;
      end
      if (cnt_ff && cmd.wr_app) begin
         start_in = cmd.app_start_val;
         end_in   = cmd.app_end_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= 1'b0;
         cnt_ff  <= is_first;
      end else begin
         scan_ff <= scan_in;
         cnt_ff  <= cnt_in;
      end
      start_ff <= start_in;
      end_ff   <= end_in;
   end

   assign scan_tok   = scan_ff;
   assign cnt_tok    = cnt_ff;
   assign scan_start = start_ff & {ADDR_W{scan_ff}};
   assign scan_end   = end_ff & {ADDR_W{scan_ff}};
   assign tail_start = start_ff & {ADDR_W{cnt_right}};
   assign tail_end   = end_ff & {ADDR_W{cnt_right}};

endmodule

// ===== rtl/frta_ctrl.sv =====
module frta_ctrl import frta_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_operation,
   input  logic [ADDR_W-1:0] req_start_addr,
   input  logic [ADDR_W-1:0] req_end_addr,
   input  logic [ADDR_W-1:0] req_request_size,
   input  logic [ADDR_W-1:0] req_request_align,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [ADDR_W-1:0] rsp_mapped_address,
   output logic [ADDR_W-1:0] rsp_granted_phys,
   output logic [ADDR_W-1:0] rsp_granted_size,
   output logic [ADDR_W-1:0] rsp_free_bytes,
   output logic [6:0]        rsp_range_count,
   output logic [ADDR_W-1:0] rsp_highest_address,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [ADDR_W-1:0] csr_map_offset,
   input  logic [ADDR_W-1:0] scan_start_bus,
   input  logic [ADDR_W-1:0] scan_end_bus,
   input  logic [ADDR_W-1:0] tail_start_bus,
   input  logic [ADDR_W-1:0] tail_end_bus,
   output cmd_type           cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DEC  = 3'd1;
   localparam logic [2:0] S_RSV  = 3'd2;
   localparam logic [2:0] S_ALA  = 3'd3;
   localparam logic [2:0] S_ALB  = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [2:0]        op_ff;
   logic [ADDR_W-1:0] s_ff, s_in, e_ff, e_in, size_ff, size_in, amask_ff, amask_in;
   logic              topf_ff, topf_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, idx_ff, idx_in;
   logic [ADDR_W-1:0] top_ff, top_in, free_ff, free_in, offset_ff;
   logic              ready_ff, ready_in;
   logic [1:0]        st_ff, st_in;
   logic              granted_ff, granted_in;
   logic [ADDR_W-1:0] gphys_ff, gphys_in, gsize_ff, gsize_in;
   logic [ADDR_W-1:0] rs_ff, re_ff, a_ff;
   logic              ao_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff;
   logic [ADDR_W-1:0] rsp_mapped_ff, rsp_gphys_ff, rsp_gsize_ff, rsp_free_ff, rsp_top_ff;
   logic [6:0]        rsp_count_ff;

   logic [ADDR_W:0]   sum_a, sum_b, a_sum, end_sum;
   logic [ADDR_W-1:0] a_val, delta;
   logic              free_upd, load_rsp, latch_a;
   logic              below, covers, fits;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      sum_a   = {1'b0, s_ff} + {1'b0, PAGE_MASK};
      sum_b   = (op_ff == OP_ALLOC) ? ({1'b0, size_ff} + {1'b0, PAGE_MASK})
                                    : ({1'b0, e_ff} + {1'b0, PAGE_MASK});
      a_sum   = {1'b0, scan_start_bus} + {1'b0, amask_ff};
      a_val   = a_sum[ADDR_W-1:0] & ~amask_ff;
      end_sum = {1'b0, a_ff} + {1'b0, size_ff};
      fits    = !ao_ff && !end_sum[ADDR_W] && (end_sum[ADDR_W-1:0] <= re_ff);
      below   = !topf_ff && (e_ff <= scan_start_bus);
      covers  = topf_ff || (e_ff >= scan_end_bus);
   end

   always_comb begin
      state_in   = state_ff;
      s_in       = s_ff;
      e_in       = e_ff;
      size_in    = size_ff;
      amask_in   = amask_ff;
      topf_in    = topf_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      top_in     = top_ff;
      ready_in   = ready_ff;
      st_in      = st_ff;
      granted_in = granted_ff;
      gphys_in   = gphys_ff;
      gsize_in   = gsize_ff;
      free_upd   = 1'b0;
      delta      = '0;
      latch_a    = 1'b0;
      load_rsp   = 1'b0;
      cmd        = '0;
      cmd.cnt_full = (cnt_ff == CNT_MAX);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               s_in       = req_start_addr;
               e_in       = req_end_addr;
               size_in    = req_request_size;
               amask_in   = req_request_align;
               granted_in = 1'b0;
               st_in      = ST_DONE;
               state_in   = S_DEC;
            end
         end
         S_DEC: begin
            state_in = S_FIN;
            case (op_ff)
               OP_CLEAR: begin
                  cmd.cnt_clr = 1'b1;
                  cnt_in      = '0;
                  top_in      = '0;
                  ready_in    = 1'b0;
                  free_upd    = 1'b1;
                  delta       = free_ff;
               end
               OP_ADD: begin
                  if (sum_a[ADDR_W] || ((e_ff & ~PAGE_MASK) <= (sum_a[ADDR_W-1:0] & ~PAGE_MASK))
                      || (cnt_ff >= CNT_MAX)) begin
                     st_in = ST_DROP;
                  end else begin
                     cmd.wr_app        = 1'b1;
                     cmd.cnt_inc       = 1'b1;
                     cmd.app_start_val = sum_a[ADDR_W-1:0] & ~PAGE_MASK;
                     cmd.app_end_val   = e_ff & ~PAGE_MASK;
                     cnt_in            = cnt_ff + 1'b1;
                     if ((e_ff & ~PAGE_MASK) > top_ff) begin
                        top_in = e_ff & ~PAGE_MASK;
                     end
                     free_upd = 1'b1;
                     delta    = cmd.app_start_val - cmd.app_end_val;
                  end
               end
               OP_RESERVE: begin
                  s_in    = s_ff & ~PAGE_MASK;
                  e_in    = sum_b[ADDR_W-1:0] & ~PAGE_MASK;
                  topf_in = sum_b[ADDR_W];
                  if (sum_b[ADDR_W] || (e_in > s_in)) begin
                     cmd.scan_rst = 1'b1;
                     idx_in       = '0;
                     state_in     = S_RSV;
                  end
               end
               OP_ALLOC: begin
                  amask_in = ((amask_ff < PAGE_LEN) ? PAGE_LEN : amask_ff) - 1'b1;
                  size_in  = sum_b[ADDR_W-1:0] & ~PAGE_MASK;
                  st_in    = ST_FAIL;
                  if (ready_ff && !sum_b[ADDR_W]) begin
                     cmd.scan_rst = 1'b1;
                     idx_in       = '0;
                     state_in     = S_ALA;
                  end
               end
               OP_READY: begin
                  ready_in = 1'b1;
               end
               default: begin
               end
            endcase
         end
         S_RSV: begin
            if (idx_ff >= cnt_ff) begin
               state_in = S_FIN;
            end else if (below || (s_ff >= scan_end_bus)) begin
               cmd.scan_adv = 1'b1;
               idx_in       = idx_ff + 1'b1;
            end else if ((s_ff <= scan_start_bus) && covers) begin
               cmd.wr_scan_start  = 1'b1;
               cmd.wr_scan_end    = 1'b1;
               cmd.scan_start_val = tail_start_bus;
               cmd.scan_end_val   = tail_end_bus;
               cmd.cnt_dec        = 1'b1;
               cnt_in             = cnt_ff - 1'b1;
               free_upd           = 1'b1;
               delta              = scan_end_bus - scan_start_bus;
            end else begin
               cmd.scan_adv = 1'b1;
               idx_in       = idx_ff + 1'b1;
               free_upd     = 1'b1;
               if (s_ff <= scan_start_bus) begin
                  cmd.wr_scan_start  = 1'b1;
                  cmd.scan_start_val = e_ff;
                  delta              = e_ff - scan_start_bus;
               end else if (covers) begin
                  cmd.wr_scan_end  = 1'b1;
                  cmd.scan_end_val = s_ff;
                  delta            = scan_end_bus - s_ff;
               end else begin
                  cmd.wr_scan_end  = 1'b1;
                  cmd.scan_end_val = s_ff;
                  if (cnt_ff < CNT_MAX) begin
                     cmd.wr_app        = 1'b1;
                     cmd.cnt_inc       = 1'b1;
                     cmd.app_start_val = e_ff;
                     cmd.app_end_val   = scan_end_bus;
                     cnt_in            = cnt_ff + 1'b1;
                     delta             = e_ff - s_ff;
                  end else begin
                     st_in = ST_DROP;
                     delta = scan_end_bus - s_ff;
                  end
               end
            end
         end
         S_ALA: begin
            if (idx_ff >= cnt_ff) begin
               state_in = S_FIN;
            end else begin
               latch_a  = 1'b1;
               state_in = S_ALB;
            end
         end
         S_ALB: begin
            if (fits) begin
               free_upd = 1'b1;
               delta    = end_sum[ADDR_W-1:0] - rs_ff;
               if (end_sum[ADDR_W-1:0] >= re_ff) begin
                  cmd.wr_scan_start  = 1'b1;
                  cmd.wr_scan_end    = 1'b1;
                  cmd.scan_start_val = tail_start_bus;
                  cmd.scan_end_val   = tail_end_bus;
                  cmd.cnt_dec        = 1'b1;
                  cnt_in             = cnt_ff - 1'b1;
               end else begin
                  cmd.wr_scan_start  = 1'b1;
                  cmd.scan_start_val = end_sum[ADDR_W-1:0];
               end
               st_in      = ST_DONE;
               granted_in = 1'b1;
               gphys_in   = a_ff;
               gsize_in   = size_ff;
               state_in   = S_FIN;
            end else begin
               cmd.scan_adv = 1'b1;
               idx_in       = idx_ff + 1'b1;
               state_in     = S_ALA;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      free_in = free_upd ? (free_ff - delta) : free_ff;
      rsp_valid_in = load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         top_ff       <= '0;
         free_ff      <= '0;
         ready_ff     <= 1'b0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         top_ff       <= top_in;
         free_ff      <= free_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            offset_ff <= csr_map_offset;
         end
      end
      if (state_ff == S_IDLE) begin
         op_ff <= req_operation;
      end
      s_ff       <= s_in;
      e_ff       <= e_in;
      size_ff    <= size_in;
      amask_ff   <= amask_in;
      topf_ff    <= topf_in;
      st_ff      <= st_in;
      granted_ff <= granted_in;
      gphys_ff   <= gphys_in;
      gsize_ff   <= gsize_in;
      if (latch_a) begin
         rs_ff <= scan_start_bus;
         re_ff <= scan_end_bus;
         a_ff  <= a_val;
         ao_ff <= a_sum[ADDR_W];
      end
      if (load_rsp) begin
         rsp_status_ff <= st_ff;
         rsp_mapped_ff <= granted_ff ? (gphys_ff + offset_ff) : '0;
         rsp_gphys_ff  <= granted_ff ? gphys_ff : '0;
         rsp_gsize_ff  <= granted_ff ? gsize_ff : '0;
         rsp_free_ff   <= free_ff;
         rsp_count_ff  <= 7'(cnt_ff);
         rsp_top_ff    <= top_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_mapped_address  = rsp_mapped_ff;
   assign rsp_granted_phys    = rsp_gphys_ff;
   assign rsp_granted_size    = rsp_gsize_ff;
   assign rsp_free_bytes      = rsp_free_ff;
   assign rsp_range_count     = rsp_count_ff;
   assign rsp_highest_address = rsp_top_ff;

endmodule

// ===== rtl/frta_checker.sv =====
module frta_checker import frta_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [1:0]        rsp_status,
   input logic [ADDR_W-1:0] rsp_mapped_address,
   input logic [ADDR_W-1:0] rsp_granted_phys,
   input logic [ADDR_W-1:0] rsp_granted_size,
   input logic [ADDR_W-1:0] rsp_free_bytes,
   input logic [6:0]        rsp_range_count
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_free_bytes)
                                  && $stable(rsp_status))
      else $error("result word changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_DONE) || (rsp_status == ST_FAIL)
                    || (rsp_status == ST_DROP))
      else $error("bad status code");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_DONE) |-> (rsp_mapped_address == '0)
                    && (rsp_granted_phys == '0) && (rsp_granted_size == '0))
      else $error("grant reported without success");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_range_count <= 7'(MAX_RANGES))
      else $error("range count beyond table size");

endmodule

bind free_range_table_allocator frta_checker u_frta_checker (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench import frta_pkg::*; ();

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] mapped;
      logic [63:0] gphys;
      logic [63:0] gsize;
      logic [63:0] free_bytes;
      logic [6:0]  count;
      logic [63:0] highest;
   } rsp_word_type;

   class range_scoreboard;
      logic [63:0] starts[MAX_RANGES];
      logic [63:0] ends[MAX_RANGES];
      int unsigned n;
      logic [63:0] top;
      bit rdy;
      logic [63:0] offset;
      rsp_word_type pending[$];
      int errors;

      function void clear_table();
         foreach (starts[i]) begin
            starts[i] = 0;
            ends[i] = 0;
         end
         n = 0;
         top = 0;
         rdy = 0;
      endfunction

      function void remove_at(int unsigned i);
         n--;
         starts[i] = starts[n];
         ends[i] = ends[n];
      endfunction

      function logic [1:0] add_range(logic [63:0] s, logic [63:0] e);
         logic [64:0] su;
         logic [63:0] sr, er;
         su = {1'b0, s} + 65'(PAGE_BYTES - 1);
         sr = su[63:0] & ~PAGE_MASK;
         er = e & ~PAGE_MASK;
         if (su[64] || er <= sr || n >= MAX_RANGES) return ST_DROP;
         starts[n] = sr;
         ends[n] = er;
         n++;
         if (er > top) top = er;
         return ST_DONE;
      endfunction

      function logic [1:0] carve_out(logic [63:0] s, logic [63:0] e);
         logic [64:0] eu;
         logic [63:0] sr, er, rs, re;
         bit wrap, below, cov;
         logic [1:0] st;
         int unsigned i;
         st = ST_DONE;
         i = 0;
         sr = s & ~PAGE_MASK;
         eu = {1'b0, e} + 65'(PAGE_BYTES - 1);
         wrap = eu[64];
         er = eu[63:0] & ~PAGE_MASK;
         if (!wrap && er <= sr) return ST_DONE;
         while (i < n) begin
            rs = starts[i];
            re = ends[i];
            below = !wrap && er <= rs;
            cov = wrap || er >= re;
            if (below || sr >= re) begin
               i++;
            end else if (sr <= rs && cov) begin
               remove_at(i);
            end else begin
               if (sr <= rs) begin
                  starts[i] = er;
               end else if (cov) begin
                  ends[i] = sr;
               end else begin
                  ends[i] = sr;
                  if (n < MAX_RANGES) begin
                     starts[n] = er;
                     ends[n] = re;
                     n++;
                  end else begin
                     st = ST_DROP;
                  end
               end
               i++;
            end
         end
         return st;
      endfunction

      function void note_request(logic [2:0] op, logic [63:0] s, logic [63:0] e,
                                 logic [63:0] sz, logic [63:0] al);
         rsp_word_type w;
         logic [64:0] t, a65, e65;
         logic [63:0] size, a, align;
         w.status = ST_DONE;
         w.mapped = 0;
         w.gphys = 0;
         w.gsize = 0;
         case (op)
            OP_CLEAR: clear_table();
            OP_ADD: w.status = add_range(s, e);
            OP_RESERVE: w.status = carve_out(s, e);
            OP_ALLOC: begin
               w.status = ST_FAIL;
               align = (al < PAGE_LEN) ? PAGE_LEN : al;
               t = {1'b0, sz} + 65'(PAGE_BYTES - 1);
               size = t[63:0] & ~PAGE_MASK;
               if (rdy && !t[64]) begin
                  for (int unsigned i = 0; i < n; i++) begin
                     a65 = {1'b0, starts[i]} + {1'b0, align - 64'd1};
                     a = a65[63:0] & ~(align - 64'd1);
                     e65 = {1'b0, a} + {1'b0, size};
                     if (a65[64] || e65[64] || e65[63:0] > ends[i]) continue;
                     starts[i] = e65[63:0];
                     if (e65[63:0] >= ends[i]) remove_at(i);
                     w.status = ST_DONE;
                     w.gphys = a;
                     w.gsize = size;
                     w.mapped = a + offset;
                     break;
                  end
               end
            end
            OP_READY: rdy = 1;
            default: ;
         endcase
         w.free_bytes = 0;
         for (int unsigned i = 0; i < n; i++) w.free_bytes += ends[i] - starts[i];
         w.count = 7'(n);
         w.highest = top;
         pending.push_back(w);
      endfunction

      function void check_result(rsp_word_type got);
         rsp_word_type x;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word status=%0d", got.status);
            return;
         end
         x = pending.pop_front();
         if (got !== x) begin
            errors++;
            if (errors <= 10)
               $display({"mismatch exp st=%0d map=%h ph=%h sz=%h free=%h n=%0d top=%h",
                         " / got st=%0d map=%h ph=%h sz=%h free=%h n=%0d top=%h"},
                  x.status, x.mapped, x.gphys, x.gsize, x.free_bytes, x.count, x.highest,
                  got.status, got.mapped, got.gphys, got.gsize, got.free_bytes, got.count,
                  got.highest);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_ready = 0, csr_valid = 0;
   logic req_ready, rsp_valid, csr_ready;
   logic [2:0] req_operation = 0;
   logic [63:0] req_start_addr = 0, req_end_addr = 0, req_request_size = 0;
   logic [63:0] req_request_align = 0, csr_map_offset = 0;
   logic [1:0] rsp_status;
   logic [63:0] rsp_mapped_address, rsp_granted_phys, rsp_granted_size;
   logic [63:0] rsp_free_bytes, rsp_highest_address;
   logic [6:0] rsp_range_count;

   range_scoreboard sb;
   int cycles = 0;
   bit hold_off = 0;
   bit stall_rsp = 0;

   free_range_table_allocator i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_operation(req_operation),
      .req_start_addr(req_start_addr), .req_end_addr(req_end_addr),
      .req_request_size(req_request_size), .req_request_align(req_request_align),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_mapped_address(rsp_mapped_address), .rsp_granted_phys(rsp_granted_phys),
      .rsp_granted_size(rsp_granted_size), .rsp_free_bytes(rsp_free_bytes),
      .rsp_range_count(rsp_range_count), .rsp_highest_address(rsp_highest_address),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_map_offset(csr_map_offset)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 600000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side
   always @(posedge clock) begin
      rsp_word_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         w.status = rsp_status;
         w.mapped = rsp_mapped_address;
         w.gphys = rsp_granted_phys;
         w.gsize = rsp_granted_size;
         w.free_bytes = rsp_free_bytes;
         w.count = rsp_range_count;
         w.highest = rsp_highest_address;
         sb.check_result(w);
      end
   end

   initial begin
      int g;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_ready <= 0;
         end else if (stall_rsp) begin
            g = gap_len();
            if (g != 0) begin
               rsp_ready <= 0;
               repeat (g) @(negedge clock);
            end
            rsp_ready <= 1;
         end else begin
            rsp_ready <= ($urandom_range(0, 3) != 0) || !stall_rsp;
         end
      end
   end

   task automatic write_offset(logic [63:0] v);
      @(negedge clock);
      csr_valid <= 1;
      csr_map_offset <= v;
      do @(posedge clock); while (!csr_ready);
      sb.offset = v;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic send_word(logic [2:0] op, logic [63:0] s, logic [63:0] e,
                            logic [63:0] sz, logic [63:0] al);
      int g;
      g = gap_len();
      if (g != 0) begin
         req_valid <= 0;
         repeat (g) @(negedge clock);
      end
      req_valid <= 1;
      req_operation <= op;
      req_start_addr <= s;
      req_end_addr <= e;
      req_request_size <= sz;
      req_request_align <= al;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, s, e, sz, al);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   function automatic logic [63:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] rnd_addr();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return rnd64();
      if (r == 1) return 64'hFFFF_FFFF_FFFF_F000 | 64'($urandom_range(0, 4095));
      return 64'($urandom_range(0, 1 << 20)) << $urandom_range(0, 12);
   endfunction

   function automatic logic [63:0] rnd_align();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 0;
      if (r == 1) return rnd64();
      if (r == 2) return 64'h8000_0000_0000_0000;
      return 64'd1 << $urandom_range(0, 20);
   endfunction

   task automatic random_item();
      int r;
      logic [63:0] s, e;
      r = $urandom_range(0, 99);
      s = rnd_addr();
      e = s + (64'($urandom_range(0, 64)) << 12) + 64'($urandom_range(0, 4095));
      if ($urandom_range(0, 9) == 0) e = rnd_addr();
      if (r < 2) send_word(OP_CLEAR, rnd64(), rnd64(), rnd64(), rnd64());
      else if (r < 40) send_word(OP_ADD, s, e, rnd64(), rnd64());
      else if (r < 55) send_word(OP_RESERVE, s, e, rnd64(), rnd64());
      else if (r < 90)
         send_word(OP_ALLOC, rnd64(), rnd64(),
                   ($urandom_range(0, 19) == 0) ? rnd64() : 64'($urandom_range(0, 40000)),
                   rnd_align());
      else if (r < 95) send_word(OP_READY, rnd64(), rnd64(), rnd64(), rnd64());
      else send_word(3'($urandom_range(5, 7)), rnd64(), rnd64(), rnd64(), rnd64());
   endtask

   initial begin
      logic [63:0] ones;
      ones = '1;
      sb = new();
      sb.clear_table();
      sb.offset = 0;
      sb.errors = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      stall_rsp = 1;

      // directed
      send_word(OP_ALLOC, 0, 0, 4096, 4096);
      send_word(OP_ADD, 64'h1001, 64'h1fff, 0, 0);
      send_word(OP_ADD, ones, ones, 0, 0);
      send_word(OP_ADD, 64'h1000, 64'h20000, 0, 0);
      send_word(OP_ADD, 64'hFFFF_FFFF_FFFF_0000, ones, 0, 0);
      send_word(OP_ALLOC, 0, 0, 4096, 0);
      send_word(OP_READY, 0, 0, 0, 0);
      send_word(OP_ALLOC, 0, 0, 0, 0);
      send_word(OP_ALLOC, 0, 0, 1, 1);
      send_word(OP_ALLOC, 0, 0, ones, 4096);
      send_word(OP_ALLOC, 0, 0, 64'h2000, 64'h8000_0000_0000_0000);
      send_word(OP_ALLOC, 0, 0, 64'h3000, 64'h3000);
      send_word(OP_RESERVE, 64'h5000, 64'h5000, 0, 0);
      send_word(OP_RESERVE, 64'h8123, 64'h9001, 0, 0);
      send_word(OP_RESERVE, 64'hFFFF_FFFF_FFFF_8000, ones, 0, 0);
      send_word(OP_RESERVE, 0, 64'h3000, 0, 0);
      send_word(3'd5, 0, 0, 0, 0);
      send_word(3'd7, ones, ones, ones, ones);
      for (int i = 0; i < 66; i++)
         send_word(OP_ADD, 64'(i) << 16, (64'(i) << 16) + 64'h8000, 0, 0);
      send_word(OP_RESERVE, 64'h2000, 64'h3000, 0, 0);
      send_word(OP_ALLOC, 0, 0, 64'h1000, 64'h1000);
      send_word(OP_CLEAR, 0, 0, 0, 0);
      drain();

      write_offset(ones);
      send_word(OP_READY, 0, 0, 0, 0);
      // long receiver hold-off while requests keep coming
      hold_off = 1;
      fork
         begin
            repeat (300) @(negedge clock);
            hold_off = 0;
         end
         for (int i = 0; i < 20; i++) random_item();
      join
      for (int phase = 0; phase < 4; phase++) begin
         for (int i = 0; i < 75; i++) begin
            if ($urandom_range(0, 60) == 0) send_word(OP_READY, 0, 0, 0, 0);
            random_item();
         end
         drain();
         case (phase)
            0: write_offset(0);
            1: write_offset(64'h8000_0000_0000_0000);
            default: write_offset(rnd64());
         endcase
         stall_rsp = (phase != 1);
      end
      drain();
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

// ===== files.f =====
rtl/frta_pkg.sv
rtl/frta_cell.sv
rtl/frta_ctrl.sv
rtl/free_range_table_allocator.sv
rtl/frta_checker.sv
sim/testbench.sv
